FILE: rtl/csv_line_field_splitter_top_assert.svh
// Assertion macros shared by the CSV line field splitter modules.
// Depends on nothing; included by the modules that carry checks.
`ifndef CSV_LINE_FIELD_SPLITTER_TOP_ASSERT_SVH
`define CSV_LINE_FIELD_SPLITTER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CSVS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csvs assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CSVS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csvs assertion failed");

`endif

FILE: rtl/csvs_pkg.sv
// Shared types and constants for the CSV line field splitter.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package csvs_pkg;

   localparam int MAX_FIELDS  = 256;
   localparam int FIELD_CNT_W = $clog2(MAX_FIELDS + 1);
   localparam int FIELD_W     = 9;
   localparam int CHAR_W      = 8;

   localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

   typedef enum logic [1:0] {
      KIND_DATA      = 2'd0,
      KIND_FIELD_END = 2'd1,
      KIND_ROW_END   = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [CHAR_W-1:0]    data_byte;
      logic [FIELD_W-1:0]   field_num;
      logic [FIELD_W-1:0]   fields_in_row;
      logic                 row_ok;
   } rsp_type;

endpackage

FILE: rtl/csvs_parse.sv
// Quote and field state tracking with per-byte result decode.
// Depends on csvs_pkg.
`timescale 1ns / 1ps

module csvs_parse
   import csvs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [FIELD_W-1:0] csr_wdata,
   input  logic               item_accept,
   input  logic [CHAR_W-1:0]  char_in,
   input  logic               line_end,
   output logic               result_valid,
   output rsp_type            result
);

   logic                   in_quote_ff, in_quote_in;
   logic                   pending_ff, pending_in;
   logic [FIELD_CNT_W-1:0] counter_ff, counter_in;
   logic                   has_chars_ff, has_chars_in;
   logic [FIELD_W-1:0]     expected_ff;

   logic                   quote_eff;
   logic                   counter_full;
   logic [FIELD_CNT_W-1:0] count_sat;

   assign counter_full = (counter_ff >= FIELD_CNT_W'(MAX_FIELDS));
   assign count_sat    = counter_full ? FIELD_CNT_W'(MAX_FIELDS)
                                      : counter_ff + FIELD_CNT_W'(1);

   always_comb begin
      in_quote_in  = in_quote_ff;
      pending_in   = 1'b0;
      counter_in   = counter_ff;
      has_chars_in = has_chars_ff;
      result_valid = 1'b0;
      result.kind          = KIND_DATA;
      result.data_byte     = CH_NUL;
      result.field_num     = FIELD_W'(counter_ff);
      result.fields_in_row = '0;
      result.row_ok        = 1'b0;
      quote_eff    = pending_ff ? 1'b0 : in_quote_ff;

      if (pending_ff && !line_end && (char_in == CH_QUOTE)) begin
         // Doubled quote inside a quoted field: one literal quote.
         result_valid     = 1'b1;
         result.data_byte = CH_QUOTE;
      end else if (line_end) begin
         result_valid         = has_chars_ff;
         result.kind          = KIND_ROW_END;
         result.fields_in_row = FIELD_W'(count_sat);
         result.row_ok        = (32'(count_sat) == 32'(expected_ff));
         in_quote_in          = 1'b0;
         counter_in           = '0;
         has_chars_in         = 1'b0;
      end else begin
         has_chars_in = 1'b1;
         in_quote_in  = quote_eff;
         if (char_in == CH_QUOTE) begin
            // A quote in quote mode waits for the next byte to decide.
            if (quote_eff) begin
               pending_in = 1'b1;
            end else begin
               in_quote_in = 1'b1;
            end
         end else if ((char_in == CH_COMMA) && !quote_eff) begin
            result_valid = 1'b1;
            result.kind  = KIND_FIELD_END;
            if (!counter_full) begin
               counter_in = counter_ff + FIELD_CNT_W'(1);
            end
         end else begin
            result_valid     = 1'b1;
            result.data_byte = char_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quote_ff  <= 1'b0;
         pending_ff   <= 1'b0;
         counter_ff   <= '0;
         has_chars_ff <= 1'b0;
         expected_ff  <= FIELD_W'(1);
      end else begin
         if (csr_we) begin
            expected_ff <= csr_wdata;
         end
         if (item_accept) begin
            in_quote_ff  <= in_quote_in;
            pending_ff   <= pending_in;
            counter_ff   <= counter_in;
            has_chars_ff <= has_chars_in;
         end
      end
   end

endmodule

FILE: rtl/csvs_skid.sv
// Two-entry output register with skid stage for result transfers.
// Depends on csvs_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`include "csv_line_field_splitter_top_assert.svh"

module csvs_skid
   import csvs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    out_valid_ff;
   logic    skid_valid_ff;
   rsp_type out_data_ff;
   rsp_type skid_data_ff;
   logic    push;
   logic    pop;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid_ff && out_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_ff  <= in_data;
            out_valid_ff <= 1'b1;
         end else begin
            skid_data_ff  <= in_data;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   `CSVS_ASSERT_IMP(skid_implies_out, clock, reset, skid_valid_ff, out_valid_ff)
   `CSVS_ASSERT_NXT(skid_held_on_stall, clock, reset, skid_valid_ff && !out_ready,
                    skid_valid_ff && $stable(skid_data_ff))
   `CSVS_ASSERT_NXT(push_on_stall_fills_skid, clock, reset,
                    push && out_valid_ff && !out_ready, skid_valid_ff)

endmodule

FILE: rtl/csv_line_field_splitter_top.sv
// Each result is registered in the output buffer; an rsp stall can hold it in the skid entry.
// One req transfer per cycle while req_tready is high; parse state updates once per byte.
// The two-entry output buffer takes one more result while rsp stalls, then drops req_tready.
// Reset (synchronous, active high) clears quote mode, the field count and both output entries,
// and sets the expected field count to one. There is no clearing pass.
`timescale 1ns / 1ps

// Top level of the CSV line field splitter. It joins the parse stage to the output buffer.
// Depends on csvs_pkg, csvs_parse and csvs_skid.
module csv_line_field_splitter_top
   import csvs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Configuration: expected field count per row.
   input  logic        csr_we,
   input  logic [8:0]  csr_wdata,
   // Input stream: one byte of a line per transfer, or an end-of-line marker.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic        req_tlast,   // line_end
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] data_byte, [16:8] field_num,
                                    // [25:17] fields_in_row, [26] row_ok, [31:27] zero
   output logic [1:0]  rsp_tuser    // [1:0] result_kind
);

   logic    item_accept;
   logic    result_valid;
   rsp_type result;
   logic    buf_ready;
   rsp_type out_data;

   // The buffer can always take one more entry unless its skid stage is full, so the
   // input side only waits when a result is stuck and another one is already queued.
   assign req_tready  = buf_ready;
   assign item_accept = req_tvalid && req_tready;

   // The parse stage updates its state on every accepted transfer and decodes at most
   // one result from the current state and the incoming byte.
   csvs_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .item_accept  (item_accept),
      .char_in      (req_tdata),
      .line_end     (req_tlast),
      .result_valid (result_valid),
      .result       (result)
   );

   // Only transfers with a result are pushed; empty lines and most quote bytes produce none.
   csvs_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (item_accept && result_valid),
      .in_ready  (buf_ready),
      .in_data   (result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tuser = out_data.kind;
   assign rsp_tdata = {5'b0, out_data.row_ok, out_data.fields_in_row,
                       out_data.field_num, out_data.data_byte};

endmodule
